FILE: hdl/assert_macros.svh
// Assertion macros used by the datapath RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ffwq_pkg.sv
// Types and constants of the first-fit waitlist queue.
package ffwq_pkg;

  localparam int NameW     = 64;
  localparam int SizeW     = 8;
  localparam int EntryW    = NameW + SizeW;
  localparam int CountOutW = 5;
  localparam int DepthDef  = 16;
  localparam logic [SizeW-1:0] MaxSizeRst = 8'd10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_LIST   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE      = 2'd1,
    ST_FULL      = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_LIST_RD,
    S_LIST_EMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    set_res;
    status_t res_code;
    logic    res_take;
    logic    ins_write;
    logic    mv_write;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_sel_next;
    logic    out_load_res;
    logic    out_load_list;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    too_large;
    logic    empty;
    logic    fits;
    logic    idx_end;
    logic    out_free;
  } stat_t;

endpackage

FILE: hdl/ffwq_ctrl.sv
// Sequencer of the waitlist queue: decodes the item and steps search, shift and list.
module ffwq_ctrl
  import ffwq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_INSERT: begin
            cmd.set_res = 1'b1;
            if (stat.full) begin
              cmd.res_code = ST_FULL;
            end else if (stat.too_large) begin
              cmd.res_code = ST_TOO_LARGE;
            end else begin
              cmd.res_code  = ST_OK;
              cmd.ins_write = 1'b1;
              cmd.cnt_inc   = 1'b1;
            end
            state_next = S_EMIT;
          end
          OP_CLEAR: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            cmd.cnt_clr  = 1'b1;
            state_next   = S_EMIT;
          end
          OP_REMOVE: begin
            if (stat.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_NONE;
              state_next   = S_EMIT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = S_SRCH_RD;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_NONE;
              state_next   = S_EMIT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = S_LIST_RD;
            end
          end
        endcase
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (stat.fits) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OK;
          cmd.res_take = 1'b1;
          state_next   = S_SHIFT_CHK;
        end else if (stat.idx_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NONE;
          state_next   = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRCH_RD;
        end
      end
      S_SHIFT_CHK: begin
        if (stat.idx_end) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.rd_sel_next = 1'b1;
          state_next      = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.mv_write = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SHIFT_CHK;
      end
      S_LIST_RD: begin
        state_next = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load_list = 1'b1;
          if (stat.idx_end) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_LIST_RD;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load_res = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/ffwq_dpath.sv
// Datapath of the waitlist queue: entry memory, count, index, limit register, output register.
`include "assert_macros.svh"

module ffwq_dpath
  import ffwq_pkg::*;
#(
  parameter int DEPTH = DepthDef
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [SizeW-1:0]     cfg_wr_data,
  input  logic [1:0]           opcode,
  input  logic [NameW-1:0]     name_tag,
  input  logic [SizeW-1:0]     entry_size,
  input  logic [SizeW-1:0]     availability,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [NameW-1:0]     name_out,
  output logic [SizeW-1:0]     size_out,
  output logic [CountOutW-1:0] entry_count,
  output logic                 last,
  input  cmd_t                 cmd,
  output stat_t                stat
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);

  logic [EntryW-1:0] mem [DEPTH];
  logic [EntryW-1:0] rdata;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic [EntryW-1:0] wr_data;
  logic              wr_en;

  logic [CntW-1:0]   cnt;
  logic [AddrW-1:0]  idx;
  logic [CntW-1:0]   idx_p1;
  logic [SizeW-1:0]  max_size;

  opcode_t           op_q;
  logic [NameW-1:0]  tag_q;
  logic [SizeW-1:0]  size_q;
  logic [SizeW-1:0]  avail_q;

  status_t           res_status;
  logic [NameW-1:0]  res_name;
  logic [SizeW-1:0]  res_size;

  logic [SizeW-1:0]  rd_size;
  logic [NameW-1:0]  rd_name;

  assign rd_size = rdata[SizeW-1:0];
  assign rd_name = rdata[EntryW-1:SizeW];
  assign idx_p1  = CntW'(idx) + CntW'(1);

  assign rd_addr = cmd.rd_sel_next ? AddrW'(idx_p1) : idx;
  assign wr_en   = cmd.ins_write | cmd.mv_write;
  assign wr_addr = cmd.ins_write ? cnt[AddrW-1:0] : idx;
  assign wr_data = cmd.ins_write ? {tag_q, size_q} : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    stat.op        = op_q;
    stat.full      = (cnt == CntW'(DEPTH));
    stat.too_large = (size_q > max_size);
    stat.empty     = (cnt == '0);
    stat.fits      = (rd_size <= avail_q);
    stat.idx_end   = (idx_p1 >= cnt);
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      max_size  <= MaxSizeRst;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_size <= cfg_wr_data;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CntW'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CntW'(1);
      end
      if (cmd.out_load_res || cmd.out_load_list) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= opcode_t'(opcode);
      tag_q   <= name_tag;
      size_q  <= entry_size;
      avail_q <= availability;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= AddrW'(idx_p1);
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_name   <= cmd.res_take ? rd_name : '0;
      res_size   <= cmd.res_take ? rd_size : '0;
    end
    if (cmd.out_load_res) begin
      status      <= res_status;
      name_out    <= res_name;
      size_out    <= res_size;
      entry_count <= CountOutW'(cnt);
      last        <= 1'b1;
    end else if (cmd.out_load_list) begin
      status      <= ST_OK;
      name_out    <= rd_name;
      size_out    <= rd_size;
      entry_count <= CountOutW'(cnt);
      last        <= stat.idx_end;
    end
  end

  `ASSERT_ON(a_cnt_bound, clk, rst, cnt <= CntW'(DEPTH), "entry count above depth")
  `ASSERT_ON(a_ins_room, clk, rst, cmd.ins_write |-> !stat.full, "insert into full list")
  `ASSERT_ON(a_out_free, clk, rst, (cmd.out_load_res || cmd.out_load_list) |-> stat.out_free, "output overwritten")
  `ASSERT_ALWAYS(a_rst_empty, clk, $past(rst) |-> (cnt == '0 && !out_valid), "state not cleared by reset")

endmodule

FILE: hdl/first_fit_waitlist_queue_unit.sv
// Top level of the first-fit waitlist queue.
//
// Input channel (in_valid/in_ready) takes one command item: insert, remove
// first fit, clear or list. Output channel (out_valid/out_ready) returns
// result items; the last one of a command has last set. max_entry_size is
// written through cfg_wr_en/cfg_wr_data by the user while the block is idle;
// the block does not enforce this. in_ready is high only while the sequencer
// is idle; a result waiting in the output register does not hold off the
// next command. Insert and clear: result set in S_EXEC, loaded in S_EMIT.
// Remove: each entry is read (S_SRCH_RD) and checked (S_SRCH_CHK) until the
// first fit; later entries move down one place via S_SHIFT_CHK, S_SHIFT_WR.
// List: each held entry is read (S_LIST_RD) and emitted (S_LIST_EMIT) as one
// result item; empty list gives one item with status 1. Its pace is set by
// the registered entry memory read. A stalled receiver holds the output
// register and the sequencer waits. Reset empties the list, sets max_entry_size
// to 10 and drops out_valid; entry memory contents are not cleared.
module first_fit_waitlist_queue_unit
  import ffwq_pkg::*;
#(
  parameter int DEPTH = DepthDef
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [SizeW-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [NameW-1:0]     name_tag,
  input  logic [SizeW-1:0]     entry_size,
  input  logic [SizeW-1:0]     availability,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [NameW-1:0]     name_out,
  output logic [SizeW-1:0]     size_out,
  output logic [CountOutW-1:0] entry_count,
  output logic                 last
);

  cmd_t  cmd;
  stat_t stat;

  ffwq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffwq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .opcode       (opcode),
    .name_tag     (name_tag),
    .entry_size   (entry_size),
    .availability (availability),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .name_out     (name_out),
    .size_out     (size_out),
    .entry_count  (entry_count),
    .last         (last),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
